FILE: sv/uri_pd_pkg.sv
// Package with the shared types and character codes of the URI percent decoder.
`timescale 1ns / 1ps

package uri_pd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_nibble;
        logic       error_seen;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_RESET = '{phase: PH_PLAIN, high_nibble: 4'd0,
                                               error_seen: 1'b0};

    typedef struct packed {
        logic       emit;
        logic [7:0] out_char;
        logic       has_char;
        logic       end_of_string;
        logic       bad_string;
    } dec_result_t;

endpackage

FILE: sv/uri_pd_if.sv
// Handshake interfaces for the encoded input stream and the decoded result stream.
`timescale 1ns / 1ps

interface uri_pd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_last;

    modport source (output valid, output in_char, output is_last, input ready);
    modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

interface uri_pd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_string;
    logic       bad_string;

    modport source (output valid, output out_char, output has_char,
                    output end_of_string, output bad_string, input ready);
    modport sink   (input valid, input out_char, input has_char,
                    input end_of_string, input bad_string, output ready);
endinterface

FILE: sv/uri_percent_decoder_core.sv
// Top level of the URI percent decoder: input register, decode and result register.
`timescale 1ns / 1ps

// Usage
// din carries one byte of an encoded URI string per item, with is_last set on
// the final byte. dout carries the decoded bytes. An item on din yields one
// result if it completes a character or closes the string, and none otherwise
// (the percent sign and first hex digit of an escape, or any byte after an error).
// The result that closes a string has end_of_string set, and bad_string tells
// the consumer to throw away everything it received for that string.
// An item accepted on din waits in the input register, and its result is
// captured in the result register as the item leaves it, which an item with a
// result cannot do while dout is stalled; valid on dout rises with that capture.
// Throughput is one item per cycle unless dout stalls; the only loop is the
// escape state, updated by one short decode step as each item leaves the input register.
// When dout is stalled the result register holds, the input register fills, and
// din.ready falls only once both are occupied. Items that give no result still
// drain from the input register while dout is stalled.
// Reset empties both registers and returns the escape state to plain characters
// with no error recorded.
module uri_percent_decoder_core (
    input  logic         clk,
    input  logic         rst_n,
    uri_pd_in_if.sink    din,
    uri_pd_out_if.source dout
);

    logic                    s1_valid_reg;
    logic [7:0]              s1_char_reg;
    logic                    s1_last_reg;
    uri_pd_pkg::dec_state_t  state_reg;
    uri_pd_pkg::dec_state_t  state_next;
    uri_pd_pkg::dec_result_t dec_res;
    uri_pd_pkg::dec_result_t res_reg;
    logic                    out_valid_reg;
    logic                    out_free;
    logic                    s1_advance;
    logic                    in_fire;

    uri_pd_decode u_decode (
        .in_char    (s1_char_reg),
        .is_last    (s1_last_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (dec_res)
    );

    assign out_free   = !out_valid_reg || dout.ready;
    assign s1_advance = s1_valid_reg && (!dec_res.emit || out_free);
    assign din.ready  = !s1_valid_reg || s1_advance;
    assign in_fire    = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= uri_pd_pkg::DEC_STATE_RESET;
        end
        else
        begin
            if (din.ready)
            begin
                s1_valid_reg <= din.valid;
            end
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
            if (s1_advance && dec_res.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= din.in_char;
            s1_last_reg <= din.is_last;
        end
        if (s1_advance && dec_res.emit)
        begin
            res_reg <= dec_res;
        end
    end

    assign dout.valid         = out_valid_reg;
    assign dout.out_char      = res_reg.out_char;
    assign dout.has_char      = res_reg.has_char;
    assign dout.end_of_string = res_reg.end_of_string;
    assign dout.bad_string    = res_reg.bad_string;

    // The escape state starts afresh after every string.
    a_state_clears_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=>
            (state_reg.phase == uri_pd_pkg::PH_PLAIN) && !state_reg.error_seen)
        else $error("escape state not cleared after the last byte of a string");

    // The input side only stalls when both registers are full and the output is blocked.
    a_stall_reason: assert property (
        @(posedge clk) disable iff (!rst_n)
        !din.ready |-> (s1_valid_reg && out_valid_reg && !dout.ready))
        else $error("input stalled without a full pipeline");

    // A decoded result always reaches the result register.
    a_result_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_advance && dec_res.emit) |=> out_valid_reg)
        else $error("decoded result lost on its way to the output");

endmodule

FILE: sv/uri_pd_decode.sv
// Combinational decode of one byte against the current escape state.
`timescale 1ns / 1ps

module uri_pd_decode (
    input  logic [7:0]              in_char,
    input  logic                    is_last,
    input  uri_pd_pkg::dec_state_t  state,
    output uri_pd_pkg::dec_state_t  state_next,
    output uri_pd_pkg::dec_result_t result
);

    logic             is_digit;
    logic             is_upper;
    logic             is_lower;
    logic             hex_ok;
    logic [3:0]       hex_val;
    logic             pass_ok;
    logic             have;
    logic [7:0]       byte_val;
    uri_pd_pkg::dec_state_t st;

    assign is_digit = (in_char >= uri_pd_pkg::CH_ZERO) && (in_char <= uri_pd_pkg::CH_NINE);
    assign is_upper = (in_char >= uri_pd_pkg::CH_UPPER_A) && (in_char <= uri_pd_pkg::CH_UPPER_Z);
    assign is_lower = (in_char >= uri_pd_pkg::CH_LOWER_A) && (in_char <= uri_pd_pkg::CH_LOWER_Z);

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (is_digit)
        begin
            hex_val = in_char[3:0];
        end
        else if ((in_char >= uri_pd_pkg::CH_UPPER_A) && (in_char <= uri_pd_pkg::CH_UPPER_F))
        begin
            hex_val = 4'(in_char - uri_pd_pkg::CH_UPPER_A + 8'd10);
        end
        else if ((in_char >= uri_pd_pkg::CH_LOWER_A) && (in_char <= uri_pd_pkg::CH_LOWER_F))
        begin
            hex_val = 4'(in_char - uri_pd_pkg::CH_LOWER_A + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign pass_ok = is_digit || is_upper || is_lower ||
                     (in_char == uri_pd_pkg::CH_MINUS) || (in_char == uri_pd_pkg::CH_UNDER) ||
                     (in_char == uri_pd_pkg::CH_DOT)   || (in_char == uri_pd_pkg::CH_TILDE) ||
                     (in_char == uri_pd_pkg::CH_STAR)  || (in_char == uri_pd_pkg::CH_SLASH) ||
                     (in_char == uri_pd_pkg::CH_PLUS);

    always_comb
    begin
        st       = state;
        have     = 1'b0;
        byte_val = 8'd0;
        if (!state.error_seen)
        begin
            case (state.phase)
                uri_pd_pkg::PH_HIGH:
                begin
                    if (!hex_ok)
                    begin
                        st.error_seen = 1'b1;
                    end
                    else
                    begin
                        st.high_nibble = hex_val;
                        st.phase       = uri_pd_pkg::PH_LOW;
                    end
                end
                uri_pd_pkg::PH_LOW:
                begin
                    if (!hex_ok)
                    begin
                        st.error_seen = 1'b1;
                    end
                    else
                    begin
                        byte_val = {state.high_nibble, hex_val};
                        have     = 1'b1;
                        st.phase = uri_pd_pkg::PH_PLAIN;
                    end
                end
                default:
                begin
                    st.phase = uri_pd_pkg::PH_PLAIN;
                    if (in_char == uri_pd_pkg::CH_PERCENT)
                    begin
                        st.phase = uri_pd_pkg::PH_HIGH;
                    end
                    else if (pass_ok)
                    begin
                        byte_val = in_char;
                        have     = 1'b1;
                    end
                    else
                    begin
                        st.error_seen = 1'b1;
                    end
                end
            endcase
        end

        // A string that ends part way through an escape is invalid.
        if (is_last && (st.phase != uri_pd_pkg::PH_PLAIN))
        begin
            st.error_seen = 1'b1;
        end
        if (st.error_seen)
        begin
            have = 1'b0;
        end

        result.emit          = have || is_last;
        result.out_char      = have ? byte_val : 8'd0;
        result.has_char      = have;
        result.end_of_string = is_last;
        result.bad_string    = is_last && st.error_seen;

        state_next = is_last ? uri_pd_pkg::DEC_STATE_RESET : st;
    end

endmodule

FILE: bench/tb_uri_percent_decoder_core.sv
// Self-checking testbench for the URI percent decoder core.
`timescale 1ns / 1ps

module tb_uri_percent_decoder_core;

    localparam int STALL_LIMIT  = 2000;
    localparam int FIRST_BATCH  = 900;
    localparam int SECOND_BATCH = 1500;
    localparam int TARGET_BYTES = 1900;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       end_of_string;
        logic       bad_string;
    } decoded_t;

    // Tracks the decoder state, predicts each result and checks what comes out.
    class decode_tracker;
        uri_pd_pkg::phase_t phase;
        logic [3:0]  high_nibble;
        bit          error_seen;
        decoded_t    decoded_due[$];
        int unsigned mismatches;
        int unsigned bytes_sent;
        int unsigned strings;
        int unsigned bad_strings;
        int unsigned results_checked;

        function new();
            phase           = uri_pd_pkg::PH_PLAIN;
            high_nibble     = 4'd0;
            error_seen      = 1'b0;
            mismatches      = 0;
            bytes_sent      = 0;
            strings         = 0;
            bad_strings     = 0;
            results_checked = 0;
        endfunction

        // Value of a hex digit, or 16 when the byte is not one.
        function logic [4:0] hex_of(logic [7:0] c);
            if (c >= uri_pd_pkg::CH_ZERO && c <= uri_pd_pkg::CH_NINE)
                return {1'b0, c[3:0]};
            if (c >= uri_pd_pkg::CH_UPPER_A && c <= uri_pd_pkg::CH_UPPER_F)
                return 5'(c - uri_pd_pkg::CH_UPPER_A + 8'd10);
            if (c >= uri_pd_pkg::CH_LOWER_A && c <= uri_pd_pkg::CH_LOWER_F)
                return 5'(c - uri_pd_pkg::CH_LOWER_A + 8'd10);
            return 5'd16;
        endfunction

        function bit passes(logic [7:0] c);
            if (c >= uri_pd_pkg::CH_ZERO && c <= uri_pd_pkg::CH_NINE)
                return 1'b1;
            if (c >= uri_pd_pkg::CH_UPPER_A && c <= uri_pd_pkg::CH_UPPER_Z)
                return 1'b1;
            if (c >= uri_pd_pkg::CH_LOWER_A && c <= uri_pd_pkg::CH_LOWER_Z)
                return 1'b1;
            return c == uri_pd_pkg::CH_MINUS || c == uri_pd_pkg::CH_UNDER ||
                   c == uri_pd_pkg::CH_DOT || c == uri_pd_pkg::CH_TILDE ||
                   c == uri_pd_pkg::CH_STAR || c == uri_pd_pkg::CH_SLASH ||
                   c == uri_pd_pkg::CH_PLUS;
        endfunction

        function void note_byte(logic [7:0] c, bit last_byte);
            logic [4:0] h;
            logic [7:0] value;
            bit         have;
            decoded_t   r;
            have  = 1'b0;
            value = 8'h00;
            h     = hex_of(c);
            bytes_sent++;
            if (!error_seen)
            begin
                case (phase)
                    uri_pd_pkg::PH_HIGH:
                    begin
                        if (h[4])
                            error_seen = 1'b1;
                        else
                        begin
                            high_nibble = h[3:0];
                            phase       = uri_pd_pkg::PH_LOW;
                        end
                    end
                    uri_pd_pkg::PH_LOW:
                    begin
                        if (h[4])
                            error_seen = 1'b1;
                        else
                        begin
                            value = {high_nibble, h[3:0]};
                            have  = 1'b1;
                            phase = uri_pd_pkg::PH_PLAIN;
                        end
                    end
                    default:
                    begin
                        phase = uri_pd_pkg::PH_PLAIN;
                        if (c == uri_pd_pkg::CH_PERCENT)
                            phase = uri_pd_pkg::PH_HIGH;
                        else if (passes(c))
                        begin
                            value = c;
                            have  = 1'b1;
                        end
                        else
                            error_seen = 1'b1;
                    end
                endcase
            end
            // A string may not finish in the middle of an escape.
            if (last_byte && phase != uri_pd_pkg::PH_PLAIN)
                error_seen = 1'b1;
            if (error_seen)
                have = 1'b0;
            if (have || last_byte)
            begin
                r.out_char      = have ? value : 8'h00;
                r.has_char      = have;
                r.end_of_string = last_byte;
                r.bad_string    = last_byte && error_seen;
                decoded_due.push_back(r);
            end
            if (last_byte)
            begin
                strings++;
                if (error_seen)
                    bad_strings++;
                phase       = uri_pd_pkg::PH_PLAIN;
                high_nibble = 4'd0;
                error_seen  = 1'b0;
            end
        endfunction

        task flag(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(decoded_t got);
            decoded_t want;
            if (decoded_due.size() == 0)
            begin
                flag($sformatf("result %02h/%0b/%0b/%0b with nothing awaited",
                               got.out_char, got.has_char, got.end_of_string,
                               got.bad_string));
                return;
            end
            want = decoded_due.pop_front();
            results_checked++;
            if (got.out_char !== want.out_char)
                flag($sformatf("out_char got %02h want %02h", got.out_char, want.out_char));
            if (got.has_char !== want.has_char)
                flag($sformatf("has_char got %0b want %0b", got.has_char, want.has_char));
            if (got.end_of_string !== want.end_of_string)
                flag($sformatf("end_of_string got %0b want %0b",
                               got.end_of_string, want.end_of_string));
            if (got.bad_string !== want.bad_string)
                flag($sformatf("bad_string got %0b want %0b",
                               got.bad_string, want.bad_string));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idling;
    int   stall_left;
    int   idle_cycles;

    decode_tracker tracker;

    uri_pd_in_if  din_if();
    uri_pd_out_if dout_if();

    uri_percent_decoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: ready drops in short random bursts while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            dout_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            dout_if.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 2);
        end
        else
            dout_if.ready <= 1'b1;
    end

    // Observes both channels and guards against a hung handshake.
    always @(posedge clk)
    begin
        bit in_fire;
        bit out_fire;
        if (rst_n)
        begin
            in_fire  = din_if.valid && din_if.ready;
            out_fire = dout_if.valid && dout_if.ready;
            if (in_fire)
                tracker.note_byte(din_if.in_char, din_if.is_last);
            if (out_fire)
                tracker.check_result({dout_if.out_char, dout_if.has_char,
                                      dout_if.end_of_string, dout_if.bad_string});
            if (in_fire || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [7:0] hex_digit(logic [3:0] n);
        if (n < 4'd10)
            return uri_pd_pkg::CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? uri_pd_pkg::CH_UPPER_A : uri_pd_pkg::CH_LOWER_A)
               + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (tracker.hex_of(b) < 5'd16)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] pick_plain();
        int k;
        k = $urandom_range(0, 68);
        if (k < 10)
            return uri_pd_pkg::CH_ZERO + 8'(k);
        if (k < 36)
            return uri_pd_pkg::CH_UPPER_A + 8'(k - 10);
        if (k < 62)
            return uri_pd_pkg::CH_LOWER_A + 8'(k - 36);
        case (k - 62)
            0:       return uri_pd_pkg::CH_MINUS;
            1:       return uri_pd_pkg::CH_UNDER;
            2:       return uri_pd_pkg::CH_DOT;
            3:       return uri_pd_pkg::CH_TILDE;
            4:       return uri_pd_pkg::CH_STAR;
            5:       return uri_pd_pkg::CH_SLASH;
            default: return uri_pd_pkg::CH_PLUS;
        endcase
    endfunction

    task automatic send_item(input logic [7:0] c, input bit last_byte);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.in_char <= c;
        din_if.is_last <= last_byte;
        do
            @(posedge clk);
        while (!din_if.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    // Mostly well-formed strings; some pure noise and some with one fault planted.
    task automatic send_random_string();
        logic [7:0] text[$];
        logic [7:0] v;
        int         n;
        int         kind;
        int         bad_at;
        n      = $urandom_range(1, 10);
        kind   = $urandom_range(0, 99);
        bad_at = (kind < 80) ? -1 : $urandom_range(0, n - 1);
        if (kind < 4)
        begin
            for (int i = 0; i < n; i++)
                text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (i == bad_at)
                begin
                    case ($urandom_range(0, 3))
                        0: text.push_back(8'($urandom_range(0, 255)));
                        1:
                        begin
                            text.push_back(uri_pd_pkg::CH_PERCENT);
                            text.push_back(non_hex());
                        end
                        2:
                        begin
                            text.push_back(uri_pd_pkg::CH_PERCENT);
                            text.push_back(hex_digit(4'($urandom_range(0, 15))));
                            text.push_back(non_hex());
                        end
                        default:
                        begin
                            // The string stops partway through an escape.
                            text.push_back(uri_pd_pkg::CH_PERCENT);
                            if ($urandom_range(0, 1))
                                text.push_back(hex_digit(4'($urandom_range(0, 15))));
                            break;
                        end
                    endcase
                end
                else if ($urandom_range(0, 99) < 65)
                    text.push_back(pick_plain());
                else
                begin
                    v = 8'($urandom_range(0, 255));
                    text.push_back(uri_pd_pkg::CH_PERCENT);
                    text.push_back(hex_digit(v[7:4]));
                    text.push_back(hex_digit(v[3:0]));
                end
            end
        end
        foreach (text[i])
            send_item(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        tracker         = new();
        rst_n           = 1'b0;
        idling          = 1'b1;
        idle_cycles     = 0;
        din_if.valid    = 1'b0;
        din_if.in_char  = 8'h00;
        din_if.is_last  = 1'b0;
        dout_if.ready   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("%00-~_.*/%fF");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_text("zZ");
        send_text("%4G9");
        send_text("A%4");
        send_text("%");
        send_text("m");

        while (tracker.bytes_sent < FIRST_BATCH)
            send_random_string();

        // Let the decoder drain completely before carrying on.
        din_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.decoded_due.size() != 0);

        while (tracker.bytes_sent < SECOND_BATCH)
            send_random_string();
        idling = 1'b0;
        while (tracker.bytes_sent < TARGET_BYTES)
            send_random_string();

        din_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.decoded_due.size() != 0);
        repeat (6) @(posedge clk);

        $display("Decoded %0d strings (%0d of them rejected) from %0d bytes;",
                 tracker.strings, tracker.bad_strings, tracker.bytes_sent);
        $display("%0d results compared, %0d mismatches.",
                 tracker.results_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
